### sv/sscs_pkg.sv
// Package for the s-expression chunk splitter.
// Holds scanner state codes, byte constants and the result beat type.
// No dependencies.
`timescale 1ns / 1ps

package sscs_pkg;

  localparam int unsigned KibW   = 22;
  localparam int unsigned KibSh  = 10;  // 1024 bytes per KiB
  localparam int unsigned LimitW = KibW + KibSh;

  localparam logic [KibW-1:0] KibReset = 22'd65536;

  localparam logic [7:0] ChOpen   = 8'h28;
  localparam logic [7:0] ChClose  = 8'h29;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;

  typedef enum logic [3:0] {
    ModeText = 4'b0001,
    ModeStr  = 4'b0010,
    ModeEsc  = 4'b0100,
    ModeCmt  = 4'b1000
  } scan_mode_e;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [15:0] chunk_index;
    logic        chunk_start;
    logic        stray_close;
    logic [15:0] nest_depth;
  } result_t;

endpackage

### sv/sscs_scan.sv
// Scanner state for the chunk splitter: mode, depth, byte and chunk counters.
// Produces the result beat for the byte presented; state advances on step_i.
// Depends on sscs_pkg.
`timescale 1ns / 1ps

module sscs_scan import sscs_pkg::*; #(
  parameter int unsigned DEPTH_BITS = 16,
  parameter int unsigned COUNT_BITS = 32,
  parameter int unsigned CHUNK_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [7:0]      byte_i,
  input  logic [KibW-1:0] min_kib_i,
  output result_t         result_o
);

  localparam int unsigned CmpW  = (COUNT_BITS > LimitW) ? COUNT_BITS : LimitW;
  localparam int unsigned DepXW = (DEPTH_BITS > 16) ? DEPTH_BITS : 16;
  localparam int unsigned ChkXW = (CHUNK_BITS > 16) ? CHUNK_BITS : 16;

  scan_mode_e            mode_q, mode_d;
  logic                  squote_q, squote_d;
  logic [DEPTH_BITS-1:0] depth_q, depth_d;
  logic [COUNT_BITS-1:0] bytes_q, bytes_d;
  logic [CHUNK_BITS-1:0] chunk_q, chunk_d;

  logic [COUNT_BITS-1:0] bytes_inc;
  logic [LimitW-1:0]     limit;
  logic                  is_text, is_open, is_close, split, stray;
  logic [7:0]            quote_ch;
  logic [DepXW-1:0]      depth_ext;
  logic [ChkXW-1:0]      chunk_ext;

  always_comb begin
    bytes_inc = (bytes_q != '1) ? bytes_q + 1'b1 : bytes_q;
    limit     = {min_kib_i, {KibSh{1'b0}}};
    is_text   = (mode_q == ModeText);
    is_open   = is_text && (byte_i == ChOpen);
    is_close  = is_text && (byte_i == ChClose);
    split     = is_open && (depth_q == '0) && (CmpW'(bytes_inc) > CmpW'(limit));
    stray     = is_close && (depth_q == '0);
    quote_ch  = squote_q ? ChSquote : ChDquote;

    bytes_d = split ? '0 : bytes_inc;
    chunk_d = (split && chunk_q != '1) ? chunk_q + 1'b1 : chunk_q;

    depth_d = depth_q;
    if (is_open && depth_q != '1) begin
      depth_d = depth_q + 1'b1;
    end else if (is_close && depth_q != '0) begin
      depth_d = depth_q - 1'b1;
    end

    mode_d   = mode_q;
    squote_d = squote_q;
    case (mode_q)
      ModeText: begin
        if (byte_i == ChDquote || byte_i == ChSquote) begin
          mode_d   = ModeStr;
          squote_d = (byte_i == ChSquote);
        end else if (byte_i == ChSemi) begin
          mode_d = ModeCmt;
        end
      end
      ModeStr: begin
        if (byte_i == ChBslash) begin
          mode_d = ModeEsc;
        end else if (byte_i == quote_ch) begin
          mode_d = ModeText;
        end
      end
      ModeEsc: begin
        mode_d = ModeStr;
      end
      ModeCmt: begin
        if (byte_i == ChNl) begin
          mode_d = ModeText;
        end
      end
      default: begin
        mode_d = ModeText;
      end
    endcase

    depth_ext = DepXW'(depth_d);
    chunk_ext = ChkXW'(chunk_d);

    result_o.out_byte    = byte_i;
    result_o.chunk_index = chunk_ext[15:0];
    result_o.chunk_start = split;
    result_o.stray_close = stray;
    result_o.nest_depth  = depth_ext[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeText;
      squote_q <= 1'b0;
      depth_q  <= '0;
      bytes_q  <= '0;
      chunk_q  <= '0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      squote_q <= squote_d;
      depth_q  <= depth_d;
      bytes_q  <= bytes_d;
      chunk_q  <= chunk_d;
    end
  end

endmodule

### sv/sexpr_stream_chunk_splitter_core.sv
// Top level of the s-expression chunk splitter: threshold register,
// scanner and a two-entry output buffer. Depends on sscs_pkg, sscs_scan.
`timescale 1ns / 1ps

// Usage:
//   Input channel: one text byte per beat on data_byte_i (in_valid_i/in_ready_o).
//   Output channel: one result beat per input byte (out_valid_o/out_ready_i),
//   carrying the byte, its chunk index, chunk start and stray close flags and
//   the nesting depth after the byte.
//   Config channel: cfg_data_i sets the minimum chunk size in KiB; ready is
//   always high. Write only while the block is idle.
// Path: an accepted byte is registered into the output register, or into the
//   skid entry while that register holds a result. Throughput: one byte per
//   cycle while out_ready_i is high, set by the scanner and output registers.
// Stall: results sit in an output register plus one skid entry, so a byte is
//   still accepted in the cycle the receiver first stalls; in_ready_o drops
//   only once both entries hold results.
// Reset: rst_ni (async, active low) puts the scanner in plain text at depth
//   zero, clears byte and chunk counters, empties the output buffer and sets
//   the threshold to 65536 KiB.

module sexpr_stream_chunk_splitter_core import sscs_pkg::*; #(
  parameter int unsigned DEPTH_BITS = 16,
  parameter int unsigned COUNT_BITS = 32,
  parameter int unsigned CHUNK_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [KibW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      data_byte_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic [15:0]     chunk_index_o,
  output logic            chunk_start_o,
  output logic            stray_close_o,
  output logic [15:0]     nest_depth_o
);

  logic [KibW-1:0] min_kib_q;
  result_t         res, out_q, skid_q;
  logic            out_valid_q, skid_valid_q;
  logic            push, pop, load_out;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !skid_valid_q;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_q && out_ready_i;
  // byte goes straight to the output register when it is free this cycle
  assign load_out    = !out_valid_q || (pop && !skid_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_kib_q <= KibReset;
    end else if (cfg_valid_i) begin
      min_kib_q <= cfg_data_i;
    end
  end

  sscs_scan #(
    .DEPTH_BITS(DEPTH_BITS),
    .COUNT_BITS(COUNT_BITS),
    .CHUNK_BITS(CHUNK_BITS)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (push),
    .byte_i   (data_byte_i),
    .min_kib_i(min_kib_q),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (push && load_out) begin
        out_valid_q <= 1'b1;
      end else if (pop && !skid_valid_q) begin
        out_valid_q <= 1'b0;
      end
      if (push && !load_out) begin
        skid_valid_q <= 1'b1;
      end else if (pop && skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && skid_valid_q) begin
      out_q <= skid_q;
    end else if (push && load_out) begin
      out_q <= res;
    end
    if (push && !load_out) begin
      skid_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_q.out_byte;
  assign chunk_index_o = out_q.chunk_index;
  assign chunk_start_o = out_q.chunk_start;
  assign stray_close_o = out_q.stray_close;
  assign nest_depth_o  = out_q.nest_depth;

endmodule

### tb/sv/sexpr_stream_chunk_splitter_core_tb.sv
// Self-checking testbench for sexpr_stream_chunk_splitter_core.
// Directed table, random s-expression text under several thresholds,
// with scoreboard prediction. Depends on sscs_pkg and the core RTL.
`timescale 1ns / 1ps

module sexpr_stream_chunk_splitter_core_tb;
  import sscs_pkg::*;

  typedef enum logic {RowByte, RowCfg} row_kind_e;

  typedef struct packed {
    row_kind_e       kind;
    logic [KibW-1:0] arg;   // byte in [7:0], or threshold
    logic            chk;   // 1: use the typed-in result below
    result_t         want;
  } row_t;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [KibW-1:0] cfg_data_i  = '0;
  logic            in_valid_i  = 1'b0;
  logic            in_ready_o;
  logic [7:0]      data_byte_i = 8'h00;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic [7:0]      out_byte_o;
  logic [15:0]     chunk_index_o;
  logic            chunk_start_o;
  logic            stray_close_o;
  logic [15:0]     nest_depth_o;

  // scanner shadow state
  scan_mode_e      scan_st   = ModeText;
  logic            in_sq     = 1'b0;
  logic [15:0]     depth_q   = '0;
  logic [31:0]     chunk_len = '0;
  logic [15:0]     chunk_cnt = '0;
  logic [KibW-1:0] kib_q     = KibReset;

  result_t pending_res[$];
  int      errors       = 0;
  bit      src_idle_en  = 1'b1;
  bit      sink_idle_en = 1'b1;

  row_t dir_tab [28] = '{
    '{RowByte, 22'(ChOpen),   1'b1, {ChOpen,  16'd0, 1'b0, 1'b0, 16'd1}},
    '{RowByte, 22'(ChClose),  1'b1, {ChClose, 16'd0, 1'b0, 1'b0, 16'd0}},
    '{RowByte, 22'(ChClose),  1'b1, {ChClose, 16'd0, 1'b0, 1'b1, 16'd0}},
    '{RowByte, 22'h00,        1'b1, {8'h00,   16'd0, 1'b0, 1'b0, 16'd0}},
    '{RowByte, 22'hFF,        1'b1, {8'hFF,   16'd0, 1'b0, 1'b0, 16'd0}},
    '{RowByte, 22'(ChDquote), 1'b0, '0},
    '{RowByte, 22'(ChOpen),   1'b0, '0},
    '{RowByte, 22'(ChBslash), 1'b0, '0},
    '{RowByte, 22'(ChDquote), 1'b0, '0},
    '{RowByte, 22'(ChSquote), 1'b0, '0},
    '{RowByte, 22'(ChDquote), 1'b0, '0},
    '{RowByte, 22'(ChSquote), 1'b0, '0},
    '{RowByte, 22'(ChClose),  1'b0, '0},
    '{RowByte, 22'(ChDquote), 1'b0, '0},
    '{RowByte, 22'(ChSquote), 1'b0, '0},
    '{RowByte, 22'(ChSemi),   1'b0, '0},
    '{RowByte, 22'(ChOpen),   1'b0, '0},
    '{RowByte, 22'(ChClose),  1'b0, '0},
    '{RowByte, 22'(ChNl),     1'b0, '0},
    '{RowCfg,  22'd0,         1'b0, '0},
    '{RowByte, 22'(ChOpen),   1'b1, {ChOpen,  16'd1, 1'b1, 1'b0, 16'd1}},
    '{RowByte, 22'(ChOpen),   1'b1, {ChOpen,  16'd1, 1'b0, 1'b0, 16'd2}},
    '{RowByte, 22'(ChClose),  1'b0, '0},
    '{RowByte, 22'(ChClose),  1'b0, '0},
    '{RowByte, 22'(ChOpen),   1'b1, {ChOpen,  16'd2, 1'b1, 1'b0, 16'd1}},
    '{RowByte, 22'(ChClose),  1'b0, '0},
    '{RowCfg,  22'h3FFFFF,    1'b0, '0},
    '{RowByte, 22'(ChOpen),   1'b1, {ChOpen,  16'd2, 1'b0, 1'b0, 16'd1}}
  };

  sexpr_stream_chunk_splitter_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .chunk_index_o (chunk_index_o),
    .chunk_start_o (chunk_start_o),
    .stray_close_o (stray_close_o),
    .nest_depth_o  (nest_depth_o)
  );

  always #5 clk_i = ~clk_i;

  // Advance the shadow scanner by one byte and return the tagged byte.
  function automatic result_t scan_byte(input logic [7:0] b);
    logic       st;
    logic       sy;
    logic [7:0] close_q;
    st = 1'b0;
    sy = 1'b0;
    close_q = in_sq ? ChSquote : ChDquote;
    if (chunk_len != '1) chunk_len++;
    case (scan_st)
      ModeText: begin
        if (b == ChOpen) begin
          if (depth_q == '0 && chunk_len > {kib_q, 10'd0}) begin
            if (chunk_cnt != '1) chunk_cnt++;
            chunk_len = '0;
            st = 1'b1;
          end
          if (depth_q != '1) depth_q++;
        end else if (b == ChClose) begin
          if (depth_q == '0) sy = 1'b1;
          else depth_q--;
        end else if (b == ChDquote || b == ChSquote) begin
          scan_st = ModeStr;
          in_sq = (b == ChSquote);
        end else if (b == ChSemi) begin
          scan_st = ModeCmt;
        end
      end
      ModeStr: begin
        if (b == ChBslash) scan_st = ModeEsc;
        else if (b == close_q) scan_st = ModeText;
      end
      ModeEsc: scan_st = ModeStr;
      default: if (b == ChNl) scan_st = ModeText;
    endcase
    return {b, chunk_cnt, st, sy, depth_q};
  endfunction

  // Text-like bytes, biased by the current scanner mode, with some noise.
  function automatic logic [7:0] pick_byte();
    int n;
    n = $urandom_range(0, 99);
    if (n >= 95) return 8'($urandom_range(0, 255));
    case (scan_st)
      ModeText: begin
        if (n < 24) return ChOpen;
        if (n < 44) return ChClose;
        if (n < 49) return ChDquote;
        if (n < 52) return ChSquote;
        if (n < 55) return ChSemi;
        if (n < 58) return ChNl;
      end
      ModeStr: begin
        if (n < 8)  return in_sq ? ChSquote : ChDquote;
        if (n < 14) return ChBslash;
        if (n < 18) return in_sq ? ChDquote : ChSquote;
        if (n < 24) return ChOpen;
      end
      ModeEsc: begin
        if (n < 15) return ChBslash;
        if (n < 30) return in_sq ? ChSquote : ChDquote;
      end
      default: begin
        if (n < 8)  return ChNl;
        if (n < 20) return (n < 14) ? ChOpen : ChClose;
      end
    endcase
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic chk, input result_t want);
    int      gap;
    result_t r;
    gap = src_idle_en ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      if (in_valid_i) in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    r = scan_byte(b);
    pending_res.push_back(chk ? want : r);
  endtask

  task automatic send_rand(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 64 == 0) src_idle_en = ($urandom_range(0, 3) != 0);
      send_byte(pick_byte(), 1'b0, '0);
    end
  endtask

  // Threshold write with the block drained.
  task automatic set_kib(input logic [KibW-1:0] v);
    if (in_valid_i) in_valid_i <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    kib_q = v;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == RowCfg) set_kib(dir_tab[i].arg);
      else send_byte(dir_tab[i].arg[7:0], dir_tab[i].chk, dir_tab[i].want);
    end

    set_kib(22'd1);
    send_rand(1060);  // enough bytes to pass 1 KiB and split
    set_kib(22'd0);
    send_rand(60);
    set_kib(22'($urandom_range(2, 22'h3FFFFE)));
    send_rand(30);

    if (in_valid_i) in_valid_i <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("sexpr_stream_chunk_splitter_core: match");
    end else begin
      $display("sexpr_stream_chunk_splitter_core: mismatch");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off to back up the input.
  initial begin : sink
    result_t got;
    result_t want;
    int      hold;
    int      n_res;
    n_res = 0;
    @(posedge rst_ni);
    forever begin
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got = {out_byte_o, chunk_index_o, chunk_start_o, stray_close_o, nest_depth_o};
      if (pending_res.size() == 0) begin
        errors++;
        if (errors <= 50)
          $display("%0t: unexpected beat, expected none, got %h", $time, got);
      end else begin
        want = pending_res.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 50)
            $display("%0t: expected %h %0d %b %b %0d, got %h %0d %b %b %0d",
                     $time, want.out_byte, want.chunk_index, want.chunk_start,
                     want.stray_close, want.nest_depth, got.out_byte, got.chunk_index,
                     got.chunk_start, got.stray_close, got.nest_depth);
        end
      end
      n_res++;
      if (n_res % 64 == 0) sink_idle_en = ($urandom_range(0, 3) != 0);
      if (n_res == 400) hold = 300;
      else hold = sink_idle_en ? $urandom_range(0, 14) : 0;
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("sexpr_stream_chunk_splitter_core: mismatch");
    $finish;
  end

endmodule
